// File: rtl/core/m3i_pkg.sv
// Shared constants for the 3x3 matrix inverse: element and column counts and cofactor operand tables.
package m3i_pkg;

  localparam int unsigned NumElems = 9;
  localparam int unsigned NumCols  = 3;

  // Cofactor k = e[CofA[k]] * e[CofB[k]] - e[CofC[k]] * e[CofD[k]]
  localparam int unsigned CofA [NumElems] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int unsigned CofB [NumElems] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int unsigned CofC [NumElems] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};
  localparam int unsigned CofD [NumElems] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};

endpackage

// File: rtl/core/m3i_cofactor.sv
// Two-stage cofactor pipeline: registered element products, then registered differences.
module m3i_cofactor #(
  parameter int unsigned DW = 32
) (
  input  logic                 clk_i,
  input  logic [1:0]           en_i,
  input  logic signed [DW-1:0] e_i   [m3i_pkg::NumElems],
  output logic signed [DW-1:0] col_o [m3i_pkg::NumCols],
  output logic signed [2*DW:0] c_o   [m3i_pkg::NumElems]
);
  import m3i_pkg::*;

  logic signed [2*DW-1:0] pa_q [NumElems];
  logic signed [2*DW-1:0] pb_q [NumElems];
  logic signed [DW-1:0]   col0_q [NumCols];
  logic signed [DW-1:0]   col1_q [NumCols];
  logic signed [2*DW:0]   c_q  [NumElems];

  // Form both products of every cofactor
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int k = 0; k < NumElems; k++) begin
        pa_q[k] <= e_i[CofA[k]] * e_i[CofB[k]];
        pb_q[k] <= e_i[CofC[k]] * e_i[CofD[k]];
      end
      for (int j = 0; j < NumCols; j++) begin
        col0_q[j] <= e_i[j];
      end
    end
  end

  // Take the differences, carry the first column along
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      for (int k = 0; k < NumElems; k++) begin
        c_q[k] <= (2*DW+1)'(pa_q[k]) - (2*DW+1)'(pb_q[k]);
      end
      for (int j = 0; j < NumCols; j++) begin
        col1_q[j] <= col0_q[j];
      end
    end
  end

  assign c_o   = c_q;
  assign col_o = col1_q;

endmodule

// File: rtl/core/m3i_det.sv
// Two-stage determinant: split partial products along the first column, then one sum.
module m3i_det #(
  parameter int unsigned DW = 32
) (
  input  logic                   clk_i,
  input  logic [1:0]             en_i,
  input  logic signed [DW-1:0]   col_i [m3i_pkg::NumCols],
  input  logic signed [2*DW:0]   c_i   [m3i_pkg::NumElems],
  output logic signed [3*DW+2:0] det_o,
  output logic signed [2*DW:0]   c_o   [m3i_pkg::NumElems]
);
  import m3i_pkg::*;

  localparam int unsigned DT = 3*DW + 3;

  logic signed [2*DW:0] pl_q [NumCols];
  logic signed [2*DW:0] ph_q [NumCols];
  logic signed [2*DW:0] c2_q [NumElems];
  logic signed [2*DW:0] c3_q [NumElems];
  logic signed [DT-1:0] det_q;

  // Multiply each column element by the low and high halves of its cofactor
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      for (int j = 0; j < NumCols; j++) begin
        pl_q[j] <= col_i[j] * $signed({1'b0, c_i[NumCols*j][DW-1:0]});
        ph_q[j] <= col_i[j] * $signed(c_i[NumCols*j][2*DW:DW]);
      end
      c2_q <= c_i;
    end
  end

  // Recombine the halves and add the three terms
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      det_q <= (DT'(ph_q[0]) <<< DW) + DT'(pl_q[0])
             + (DT'(ph_q[1]) <<< DW) + DT'(pl_q[1])
             + (DT'(ph_q[2]) <<< DW) + DT'(pl_q[2]);
      c3_q  <= c2_q;
    end
  end

  assign det_o = det_q;
  assign c_o   = c3_q;

endmodule

// File: rtl/core/m3i_div.sv
// Pipelined restoring divider for one element: cofactor scaled by 2^(2F) over the determinant.
module m3i_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned FW = 16
) (
  input  logic                   clk_i,
  input  logic [DW+2:0]          en_i,
  input  logic signed [2*DW:0]   c_i,
  input  logic signed [3*DW+2:0] det_i,
  output logic [DW-1:0]          res_o,
  output logic                   sat_o,
  output logic                   zero_o
);

  localparam int unsigned CW   = 2*DW + 1;
  localparam int unsigned DT   = 3*DW + 3;
  localparam int unsigned NIT  = DW + 1;
  localparam int unsigned NUMW = CW + 2*FW;
  localparam int unsigned SHW  = DT + NIT;
  localparam int unsigned RW   = (NUMW > SHW) ? NUMW : SHW;

  logic [CW-1:0]  cabs;
  logic [DT-1:0]  dabs;
  logic [RW-1:0]  num;
  logic [RW-1:0]  dsh;

  logic [RW-1:0]  rem_q  [NIT+1];
  logic [DT-1:0]  dm_q   [NIT+1];
  logic [NIT-1:0] q_q    [NIT+1];
  logic           neg_q  [NIT+1];
  logic           zro_q  [NIT+1];
  logic           big_q  [NIT+1];

  logic [DW-1:0]  res_q;
  logic           sat_q;
  logic           zero_q;

  // Magnitudes, sign of the quotient and the early out-of-range test
  always_comb begin
    cabs = c_i[CW-1] ? CW'(-c_i) : CW'(c_i);
    dabs = det_i[DT-1] ? DT'(-det_i) : DT'(det_i);
    num  = RW'(cabs) << (2*FW);
    dsh  = RW'(dabs) << NIT;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0] <= num;
      dm_q[0]  <= dabs;
      q_q[0]   <= '0;
      neg_q[0] <= c_i[CW-1] ^ det_i[DT-1];
      zro_q[0] <= (det_i == '0);
      big_q[0] <= (num >= dsh);
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar t = 0; t < NIT; t++) begin : g_iter
    localparam int unsigned B = NIT - 1 - t;
    logic [RW-1:0] trial;
    logic          ge;

    assign trial = RW'(dm_q[t]) << B;
    assign ge    = (rem_q[t] >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i[t+1]) begin
        rem_q[t+1] <= ge ? (rem_q[t] - trial) : rem_q[t];
        q_q[t+1]   <= q_q[t] | (NIT'(ge) << B);
        dm_q[t+1]  <= dm_q[t];
        neg_q[t+1] <= neg_q[t];
        zro_q[t+1] <= zro_q[t];
        big_q[t+1] <= big_q[t];
      end
    end
  end

  // Apply sign, saturate, and clear on a singular matrix
  logic [NIT-1:0] qf;
  logic           pos_ovf;
  logic           neg_ovf;
  logic [DW-1:0]  max_pos;
  logic [DW-1:0]  min_neg;

  always_comb begin
    qf      = q_q[NIT];
    max_pos = {1'b0, {(DW-1){1'b1}}};
    min_neg = {1'b1, {(DW-1){1'b0}}};
    pos_ovf = big_q[NIT] | qf[DW] | qf[DW-1];
    neg_ovf = big_q[NIT] | qf[DW] | (qf[DW-1] & (|qf[DW-2:0]));
  end

  always_ff @(posedge clk_i) begin
    if (en_i[NIT+1]) begin
      zero_q <= zro_q[NIT];
      if (zro_q[NIT]) begin
        res_q <= '0;
        sat_q <= 1'b0;
      end else if (neg_q[NIT]) begin
        res_q <= neg_ovf ? min_neg : (-qf[DW-1:0]);
        sat_q <= neg_ovf;
      end else begin
        res_q <= pos_ovf ? max_pos : qf[DW-1:0];
        sat_q <= pos_ovf;
      end
    end
  end

  assign res_o  = res_q;
  assign sat_o  = sat_q;
  assign zero_o = zero_q;

endmodule

// File: rtl/core/matrix3x3_inverse_unit.sv
// Pipeline: a one-bit-per-stage divider follows two cofactor stages and two determinant stages.
// Throughput: one request per cycle while in_stall_o is low; each stage moves on when it
// is empty or its successor moves, so bubbles close up behind a stalled output.
// Reset: rst_ni clears the per-stage valid bits only; the datapath registers are not reset.
// Top level: 3x3 inverse by cofactors, determinant and nine pipelined dividers.
module matrix3x3_inverse_unit #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] in_e0_i,
  input  logic signed [DATA_WIDTH-1:0] in_e1_i,
  input  logic signed [DATA_WIDTH-1:0] in_e2_i,
  input  logic signed [DATA_WIDTH-1:0] in_e3_i,
  input  logic signed [DATA_WIDTH-1:0] in_e4_i,
  input  logic signed [DATA_WIDTH-1:0] in_e5_i,
  input  logic signed [DATA_WIDTH-1:0] in_e6_i,
  input  logic signed [DATA_WIDTH-1:0] in_e7_i,
  input  logic signed [DATA_WIDTH-1:0] in_e8_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] out_e0_o,
  output logic signed [DATA_WIDTH-1:0] out_e1_o,
  output logic signed [DATA_WIDTH-1:0] out_e2_o,
  output logic signed [DATA_WIDTH-1:0] out_e3_o,
  output logic signed [DATA_WIDTH-1:0] out_e4_o,
  output logic signed [DATA_WIDTH-1:0] out_e5_o,
  output logic signed [DATA_WIDTH-1:0] out_e6_o,
  output logic signed [DATA_WIDTH-1:0] out_e7_o,
  output logic signed [DATA_WIDTH-1:0] out_e8_o,
  output logic                         singular_o,
  output logic                         overflow_o
);
  import m3i_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned NS = DW + 7;

  logic                   vld_q [NS];
  logic [NS-1:0]          en;

  logic signed [DW-1:0]   elem  [NumElems];
  logic signed [DW-1:0]   col   [NumCols];
  logic signed [2*DW:0]   cof1  [NumElems];
  logic signed [2*DW:0]   cof3  [NumElems];
  logic signed [3*DW+2:0] det;
  logic [DW-1:0]          res   [NumElems];
  logic [NumElems-1:0]    sat;
  logic [NumElems-1:0]    zro;

  // Advance a stage when it is empty or the next stage advances
  always_comb begin
    en[NS-1] = !vld_q[NS-1] || !out_stall_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  // Carry valid bits down the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = vld_q[NS-1];

  assign elem = '{in_e0_i, in_e1_i, in_e2_i, in_e3_i, in_e4_i,
                  in_e5_i, in_e6_i, in_e7_i, in_e8_i};

  m3i_cofactor #(.DW(DW)) u_cof (
    .clk_i (clk_i),
    .en_i  (en[1:0]),
    .e_i   (elem),
    .col_o (col),
    .c_o   (cof1)
  );

  m3i_det #(.DW(DW)) u_det (
    .clk_i (clk_i),
    .en_i  (en[3:2]),
    .col_i (col),
    .c_i   (cof1),
    .det_o (det),
    .c_o   (cof3)
  );

  for (genvar k = 0; k < NumElems; k++) begin : g_div
    m3i_div #(.DW(DW), .FW(FRAC_BITS)) u_div (
      .clk_i  (clk_i),
      .en_i   (en[NS-1:4]),
      .c_i    (cof3[k]),
      .det_i  (det),
      .res_o  (res[k]),
      .sat_o  (sat[k]),
      .zero_o (zro[k])
    );
  end

  assign out_e0_o   = res[0];
  assign out_e1_o   = res[1];
  assign out_e2_o   = res[2];
  assign out_e3_o   = res[3];
  assign out_e4_o   = res[4];
  assign out_e5_o   = res[5];
  assign out_e6_o   = res[6];
  assign out_e7_o   = res[7];
  assign out_e8_o   = res[8];
  assign singular_o = zro[0];
  assign overflow_o = |sat;

  // All dividers see the same determinant, so the other zero flags are redundant
  logic unused_zro;
  assign unused_zro = ^zro[NumElems-1:1];

endmodule
